/* design/dfhd_pkg.sv */
// ----------------------------------------------------------------------------
// Display frame height decoder package
// Types, constants and the seven-segment lookup shared by the decoder files.
// ----------------------------------------------------------------------------
package dfhd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned HeightWidth = 16;
   localparam int unsigned DigitCount  = 3;
   localparam int unsigned FrameBytes  = 4;

   localparam logic [ByteWidth-1:0] SYNC_BYTE    = 8'h5A;
   localparam logic [ByteWidth-1:0] FLAG_ON_MASK = 8'h10;
   localparam logic [ByteWidth-1:0] DOT_MASK     = 8'h80;
   localparam logic [ByteWidth-1:0] SEG_MASK     = 8'h7F;
   localparam logic [ByteWidth-1:0] NO_MATCH     = 8'hFF;

   localparam logic [ByteWidth-1:0] ERR_PAT_0 = 8'h76;
   localparam logic [ByteWidth-1:0] ERR_PAT_1 = 8'h5C;
   localparam logic [ByteWidth-1:0] ERR_PAT_2 = 8'h78;
   localparam logic [ByteWidth-1:0] RST_PAT_0 = 8'h50;
   localparam logic [ByteWidth-1:0] RST_PAT_1 = 8'h6D;
   localparam logic [ByteWidth-1:0] RST_PAT_2 = 8'h31;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_HEIGHT      = 3'd0,
      STATUS_DISPLAY_OFF = 3'd1,
      STATUS_ERROR_PAT   = 3'd2,
      STATUS_RESET_PAT   = 3'd3,
      STATUS_LETTER      = 3'd4,
      STATUS_BAD_SUM     = 3'd5
   } status_type;

   typedef logic [FrameBytes-1:0][ByteWidth-1:0] frame_type;

   typedef struct packed {
      status_type             status;
      logic [HeightWidth-1:0] height_value;
      logic                   digit_unmatched;
   } result_type;

   function automatic logic [ByteWidth-1:0] numeral_value(input logic [ByteWidth-1:0] seg);
      logic [ByteWidth-1:0] masked;
      masked = seg & SEG_MASK;
      unique case (masked)
         8'h3F:   numeral_value = 8'd0;
         8'h06:   numeral_value = 8'd1;
         8'h5B:   numeral_value = 8'd2;
         8'h4F:   numeral_value = 8'd3;
         8'h66:   numeral_value = 8'd4;
         8'h6D:   numeral_value = 8'd5;
         8'h7D:   numeral_value = 8'd6;
         8'h07:   numeral_value = 8'd7;
         8'h7F:   numeral_value = 8'd8;
         8'h6F:   numeral_value = 8'd9;
         default: numeral_value = NO_MATCH;
      endcase
   endfunction

endpackage

/* design/display_frame_height_decoder.sv */
// ----------------------------------------------------------------------------
// Display frame height decoder
// Hunts for frames in a controller byte stream and reports each frame decoded.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle except when it is a checksum byte and
// the previous result is still stalled in the output register. It waits for
// the sync byte 5Ah, collects three seven-segment digit bytes, a flag byte
// and a checksum, and delivers one result item in the cycle after the checksum
// byte is accepted; all other bytes give no result.
module display_frame_height_decoder
   import dfhd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ByteWidth-1:0]   req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [HeightWidth-1:0] rsp_height_value,
   output logic                   rsp_digit_unmatched
);

   typedef enum logic [5:0] {
      POS_HUNT  = 6'b000001,
      POS_DIG0  = 6'b000010,
      POS_DIG1  = 6'b000100,
      POS_DIG2  = 6'b001000,
      POS_FLAG  = 6'b010000,
      POS_CHECK = 6'b100000
   } position_type;

   position_type         position_ff, position_in;
   frame_type            frame_ff, frame_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff, result_in;
   result_type           decoded;
   logic                 req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall && (position_ff == POS_CHECK);
   assign req_accept = req_valid && !req_stall;

   dfhd_decode u_decode (
      .frame       (frame_ff),
      .running_sum (sum_ff),
      .check       (req_rx_byte),
      .result      (decoded)
   );

   always_comb begin
      position_in  = position_ff;
      frame_in     = frame_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      result_in    = result_ff;
      if (req_accept) begin
         unique case (position_ff)
            POS_DIG0: begin
               frame_in[0] = req_rx_byte;
               sum_in      = sum_ff + req_rx_byte;
               position_in = POS_DIG1;
            end
            POS_DIG1: begin
               frame_in[1] = req_rx_byte;
               sum_in      = sum_ff + req_rx_byte;
               position_in = POS_DIG2;
            end
            POS_DIG2: begin
               frame_in[2] = req_rx_byte;
               sum_in      = sum_ff + req_rx_byte;
               position_in = POS_FLAG;
            end
            POS_FLAG: begin
               frame_in[3] = req_rx_byte;
               sum_in      = sum_ff + req_rx_byte;
               position_in = POS_CHECK;
            end
            POS_CHECK: begin
               result_in    = decoded;
               rsp_valid_in = 1'b1;
               position_in  = POS_HUNT;
            end
            default: begin
               if (req_rx_byte == SYNC_BYTE) begin
                  position_in = POS_DIG0;
                  sum_in      = '0;
               end else begin
                  position_in = POS_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= POS_HUNT;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = result_ff.status;
   assign rsp_height_value    = result_ff.height_value;
   assign rsp_digit_unmatched = result_ff.digit_unmatched;

endmodule

/* design/dfhd_decode.sv */
// ----------------------------------------------------------------------------
// Display frame decode
// Turns a collected frame and its check byte into one status, height result.
// ----------------------------------------------------------------------------
module dfhd_decode
   import dfhd_pkg::*;
(
   input  frame_type            frame,
   input  logic [ByteWidth-1:0] running_sum,
   input  logic [ByteWidth-1:0] check,
   output result_type           result
);

   logic [ByteWidth-1:0]   d0;
   logic [ByteWidth-1:0]   d1;
   logic [ByteWidth-1:0]   d2;
   logic                   err_match;
   logic                   rst_match;
   logic [HeightWidth-1:0] height;

   assign d0 = numeral_value(frame[0]);
   assign d1 = numeral_value(frame[1]);
   assign d2 = numeral_value(frame[2]);

   assign err_match = (frame[0] == ERR_PAT_0) && (frame[1] == ERR_PAT_1) &&
                      (frame[2] == ERR_PAT_2);
   assign rst_match = (frame[0] == RST_PAT_0) && (frame[1] == RST_PAT_1) &&
                      (frame[2] == RST_PAT_2);

   always_comb begin
      if ((frame[1] & DOT_MASK) != '0) begin
         height = HeightWidth'(d0) * 16'd100 + HeightWidth'(d1) * 16'd10 +
                  HeightWidth'(d2);
      end else begin
         height = HeightWidth'(d0) * 16'd1000 + HeightWidth'(d1) * 16'd100 +
                  HeightWidth'(d2) * 16'd10;
      end
   end

   always_comb begin
      result.status          = STATUS_HEIGHT;
      result.height_value    = '0;
      result.digit_unmatched = 1'b0;
      priority if (check != running_sum) begin
         result.status = STATUS_BAD_SUM;
      end else if ((frame[3] & FLAG_ON_MASK) == '0) begin
         result.status = STATUS_DISPLAY_OFF;
      end else if (err_match) begin
         result.status = STATUS_ERROR_PAT;
      end else if (rst_match) begin
         result.status = STATUS_RESET_PAT;
      end else if (d0 == NO_MATCH) begin
         result.status = STATUS_LETTER;
      end else begin
         result.height_value    = height;
         result.digit_unmatched = (d1 == NO_MATCH) || (d2 == NO_MATCH);
      end
   end

endmodule
